### rtl/sgfr_pkg.sv
package sgfr_pkg;

	localparam logic [7:0]  SYNC_BYTE    = 8'hAA;
	localparam logic [7:0]  TYPE_BUTTONS = 8'h42;
	localparam logic [7:0]  TYPE_SYSTEM  = 8'h43;
	localparam logic [7:0]  TYPE_PONG    = 8'h50;
	localparam logic [1:0]  LAST_BYTE    = 2'd2;
	localparam logic [15:0] DEFAULT_MS   = 16'd500;
	localparam logic [15:0] MS_MAX       = 16'hFFFF;

	localparam int APB_AW = 3;

	typedef enum logic {
		REG_LINK_TIMEOUT = 1'b0,
		REG_INJECT_HOLD  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_INJECT = 2'd2,
		ACT_POLL   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_BUTTONS   = 3'd1,
		ST_SYSTEM    = 3'd2,
		ST_PONG      = 3'd3,
		ST_CHECK_ERR = 3'd4,
		ST_UNKNOWN   = 3'd5
	} frame_status_t;

	typedef struct packed {
		logic        in_frame;
		logic [1:0]  byte_count;
		logic [7:0]  frame_type;
		logic [7:0]  frame_data;
		logic [7:0]  button_state;
		logic [7:0]  system_state;
		logic [7:0]  previous_buttons;
		logic        packet_seen;
		logic [15:0] since_packet_ms;
		logic [7:0]  held_mask;
		logic [15:0] mask_age_ms;
	} sgfr_state_t;

	typedef struct packed {
		frame_status_t frame_status;
		logic          connected;
		logic [7:0]    newly_pressed;
		logic [7:0]    system_buttons;
		logic [7:0]    buttons;
	} sgfr_result_t;

	localparam sgfr_state_t STATE_RESET = '0;

endpackage

### rtl/sgfr_step.sv
module sgfr_step (
	input  sgfr_pkg::sgfr_state_t  cur,
	input  sgfr_pkg::action_t      action,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             inject_mask,
	input  logic [15:0]            link_timeout_ms,
	input  logic [15:0]            inject_hold_ms,
	output sgfr_pkg::sgfr_state_t  nxt,
	output sgfr_pkg::sgfr_result_t res
);
	import sgfr_pkg::*;

	logic [7:0]    cur_buttons;
	logic [7:0]    new_buttons;
	logic          check_ok;
	frame_status_t status;
	logic [7:0]    newly;

	assign cur_buttons = cur.button_state |
		((cur.mask_age_ms < inject_hold_ms) ? cur.held_mask : 8'h00);
	assign check_ok = (rx_byte == ~cur.frame_data);

	always_comb begin
		nxt    = cur;
		status = ST_NONE;
		newly  = 8'h00;
		case (action)
			ACT_BYTE: begin
				if (!cur.in_frame) begin
					if (rx_byte == SYNC_BYTE) begin
						nxt.in_frame   = 1'b1;
						nxt.byte_count = 2'd0;
					end
				end else if (cur.byte_count == 2'd0) begin
					nxt.frame_type = rx_byte;
					nxt.byte_count = 2'd1;
				end else if (cur.byte_count == 2'd1) begin
					nxt.frame_data = rx_byte;
					nxt.byte_count = LAST_BYTE;
				end else begin
					nxt.in_frame   = 1'b0;
					nxt.byte_count = 2'd0;
					if (cur.frame_type == TYPE_BUTTONS || cur.frame_type == TYPE_SYSTEM) begin
						if (!check_ok) begin
							status = ST_CHECK_ERR;
						end else begin
							nxt.packet_seen     = 1'b1;
							nxt.since_packet_ms = '0;
							if (cur.frame_type == TYPE_BUTTONS) begin
								nxt.button_state = cur.frame_data;
								status           = ST_BUTTONS;
							end else begin
								nxt.system_state = cur.frame_data;
								status           = ST_SYSTEM;
							end
						end
					end else if (cur.frame_type == TYPE_PONG) begin
						nxt.packet_seen     = 1'b1;
						nxt.since_packet_ms = '0;
						status              = ST_PONG;
					end else begin
						status = ST_UNKNOWN;
					end
				end
			end
			ACT_TICK: begin
				if (cur.since_packet_ms != MS_MAX)
					nxt.since_packet_ms = cur.since_packet_ms + 16'd1;
				if (cur.held_mask != 8'h00) begin
					if (cur.mask_age_ms != MS_MAX)
						nxt.mask_age_ms = cur.mask_age_ms + 16'd1;
					if (nxt.mask_age_ms >= inject_hold_ms)
						nxt.held_mask = 8'h00;
				end
			end
			ACT_INJECT: begin
				nxt.held_mask   = inject_mask;
				nxt.mask_age_ms = '0;
			end
			ACT_POLL: begin
				newly                = cur_buttons & ~cur.previous_buttons;
				nxt.previous_buttons = cur_buttons;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign new_buttons = nxt.button_state |
		((nxt.mask_age_ms < inject_hold_ms) ? nxt.held_mask : 8'h00);

	always_comb begin
		res.buttons        = new_buttons;
		res.system_buttons = nxt.system_state;
		res.newly_pressed  = newly;
		res.connected      = nxt.packet_seen && (nxt.since_packet_ms < link_timeout_ms);
		res.frame_status   = status;
	end

endmodule

### rtl/serial_gamepad_frame_receiver.sv
// Serial gamepad frame receiver.
// Input stream (s_*): one transfer per event. s_tuser carries the action
// (received byte, millisecond tick, inject mask, poll new presses); s_tdata
// carries the received byte and the inject mask.
// Output stream (m_*): exactly one result transfer per input transfer, in
// order: current buttons (with active injected mask), system buttons, newly
// pressed bits on a poll, link connected flag and the status of a frame
// completed by this byte.
// The state is updated and the result registered at the edge that accepts
// the input. One item per cycle is taken as long as the output register is
// empty or being emptied in the same cycle; a stalled m_tready holds the
// result and stalls s_tready after one item.
// APB port: link_timeout_ms at 0x0, inject_hold_ms at 0x4 (16 bits each,
// reset 500). Write only while the stream is idle.
// Reset clears all frame, button and link state and empties the output
// register.
module serial_gamepad_frame_receiver (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sgfr_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // rx_byte, inject_mask
	input  logic [1:0]                   s_tuser,   // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata    // buttons, system_buttons,
	                                                // newly_pressed, connected,
	                                                // frame_status, zero pad
);
	import sgfr_pkg::*;

	logic [15:0]  link_timeout_q;
	logic [15:0]  inject_hold_q;
	sgfr_state_t  state_q;
	sgfr_state_t  state_nxt;
	sgfr_result_t res_nxt;
	sgfr_result_t res_q;
	logic         out_valid_q;
	logic         s_fire;
	logic         cfg_wr;
	reg_idx_t     cfg_idx;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign cfg_idx  = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_timeout_q <= DEFAULT_MS;
			inject_hold_q  <= DEFAULT_MS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LINK_TIMEOUT: link_timeout_q <= pwdata[15:0];
				REG_INJECT_HOLD:  inject_hold_q  <= pwdata[15:0];
				default:          link_timeout_q <= link_timeout_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_LINK_TIMEOUT: prdata = {16'h0000, link_timeout_q};
			REG_INJECT_HOLD:  prdata = {16'h0000, inject_hold_q};
			default:          prdata = '0;
		endcase
	end

	assign s_tready = !out_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	sgfr_step u_step (
		.cur             (state_q),
		.action          (action_t'(s_tuser)),
		.rx_byte         (s_tdata[7:0]),
		.inject_mask     (s_tdata[15:8]),
		.link_timeout_ms (link_timeout_q),
		.inject_hold_ms  (inject_hold_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (s_fire)
				state_q <= state_nxt;
			if (s_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, res_q};

endmodule

### verif/serial_gamepad_frame_receiver_tb.sv
module serial_gamepad_frame_receiver_tb;
	import sgfr_pkg::*;

	localparam int          HOLD_CYCLES = 300;
	localparam int unsigned LIMIT       = 1_000_000;
	localparam int          RES_W       = $bits(sgfr_result_t);

	class gamepad_scoreboard;
		logic [15:0]  link_timeout;
		logic [15:0]  inject_hold;
		logic         in_frame;
		logic [1:0]   byte_cnt;
		logic [7:0]   ftype;
		logic [7:0]   fdata;
		logic [7:0]   btn;
		logic [7:0]   sys;
		logic [7:0]   prev_btn;
		logic         seen;
		logic [15:0]  since;
		logic [7:0]   held;
		logic [15:0]  mask_age;
		sgfr_result_t reports[$];
		int           mismatches;

		function new();
			link_timeout = DEFAULT_MS;
			inject_hold  = DEFAULT_MS;
			in_frame     = 1'b0;
			byte_cnt     = '0;
			ftype        = '0;
			fdata        = '0;
			btn          = '0;
			sys          = '0;
			prev_btn     = '0;
			seen         = 1'b0;
			since        = '0;
			held         = '0;
			mask_age     = '0;
			mismatches   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			if (idx == REG_LINK_TIMEOUT)
				link_timeout = v;
			else
				inject_hold = v;
		endfunction

		function logic [7:0] live_buttons();
			return btn | ((mask_age < inject_hold) ? held : 8'h00);
		endfunction

		function frame_status_t take_byte(logic [7:0] b);
			logic ok;
			if (!in_frame) begin
				if (b == SYNC_BYTE) begin
					in_frame = 1'b1;
					byte_cnt = 2'd0;
				end
				return ST_NONE;
			end
			if (byte_cnt == 2'd0) begin
				ftype    = b;
				byte_cnt = 2'd1;
				return ST_NONE;
			end
			if (byte_cnt == 2'd1) begin
				fdata    = b;
				byte_cnt = LAST_BYTE;
				return ST_NONE;
			end
			in_frame = 1'b0;
			byte_cnt = 2'd0;
			ok = (b == ~fdata);
			if (ftype == TYPE_BUTTONS || ftype == TYPE_SYSTEM) begin
				if (!ok)
					return ST_CHECK_ERR;
				seen  = 1'b1;
				since = '0;
				if (ftype == TYPE_BUTTONS) begin
					btn = fdata;
					return ST_BUTTONS;
				end
				sys = fdata;
				return ST_SYSTEM;
			end
			if (ftype == TYPE_PONG) begin
				seen  = 1'b1;
				since = '0;
				return ST_PONG;
			end
			return ST_UNKNOWN;
		endfunction

		function void note_event(action_t act, logic [7:0] rx, logic [7:0] inj);
			frame_status_t st;
			logic [7:0]    newly;
			logic [7:0]    cur;
			sgfr_result_t  r;
			st    = ST_NONE;
			newly = '0;
			case (act)
				ACT_BYTE: st = take_byte(rx);
				ACT_TICK: begin
					since = (since == MS_MAX) ? MS_MAX : since + 16'd1;
					if (held != 8'h00) begin
						mask_age = (mask_age == MS_MAX) ? MS_MAX : mask_age + 16'd1;
						if (mask_age >= inject_hold)
							held = 8'h00;
					end
				end
				ACT_INJECT: begin
					held     = inj;
					mask_age = '0;
				end
				default: begin
					cur      = live_buttons();
					newly    = cur & ~prev_btn;
					prev_btn = cur;
				end
			endcase
			r.buttons        = live_buttons();
			r.system_buttons = sys;
			r.newly_pressed  = newly;
			r.connected      = seen && (since < link_timeout);
			r.frame_status   = st;
			reports.push_back(r);
		endfunction

		function void check_report(logic [31:0] data);
			sgfr_result_t want;
			sgfr_result_t got;
			got = sgfr_result_t'(data[RES_W-1:0]);
			if (reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %h", data);
				return;
			end
			want = reports.pop_front();
			if (got.buttons !== want.buttons ||
			    got.system_buttons !== want.system_buttons ||
			    got.newly_pressed !== want.newly_pressed ||
			    got.connected !== want.connected ||
			    got.frame_status !== want.frame_status ||
			    data[31:RES_W] !== '0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp btn=%h sys=%h new=%h conn=%b st=%0d",
					         want.buttons, want.system_buttons, want.newly_pressed,
					         want.connected, want.frame_status);
					$display("          got btn=%h sys=%h new=%h conn=%b st=%0d pad=%h",
					         got.buttons, got.system_buttons, got.newly_pressed,
					         got.connected, got.frame_status, data[31:RES_W]);
				end
			end
		endfunction

		function int pending();
			return reports.size();
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_AW-1:0]     paddr    = '0;
	logic [31:0]           pwdata   = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata  = '0;
	logic [1:0]            s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;

	gamepad_scoreboard sb = new();

	int          items_sent = 0;
	bit          snd_idle   = 1'b0;
	bit          rcv_idle   = 1'b0;
	bit          hold_req   = 1'b0;
	int          stall_left = 0;
	int unsigned cycles     = 0;

	serial_gamepad_frame_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_report(m_tdata);
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req   = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rcv_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input action_t act, input logic [7:0] rx, input logic [7:0] inj);
		if (snd_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {inj, rx};
		do @(posedge clk); while (!s_tready);
		sb.note_event(act, rx, inj);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] ft, input logic [7:0] fd, input logic [7:0] fc);
		send_item(ACT_BYTE, SYNC_BYTE, 8'($urandom));
		send_item(ACT_BYTE, ft, 8'($urandom));
		send_item(ACT_BYTE, fd, 8'($urandom));
		send_item(ACT_BYTE, fc, 8'($urandom));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= {16'h0000, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic configure(input logic [15:0] timeout_ms, input logic [15:0] hold_ms);
		wait_drain();
		apb_write(REG_LINK_TIMEOUT, timeout_ms);
		apb_write(REG_INJECT_HOLD, hold_ms);
	endtask

	// mostly well-formed frames, mixed with ticks, injects, polls and line noise
	task automatic run_random(input int n);
		int         stop;
		int         r;
		logic [7:0] d;
		logic [7:0] t;
		logic [7:0] c;
		stop = items_sent + n;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				d = 8'($urandom);
				case ($urandom_range(0, 9))
					0, 1, 2: t = TYPE_BUTTONS;
					3, 4, 5: t = TYPE_SYSTEM;
					6:       t = TYPE_PONG;
					7:       t = SYNC_BYTE;
					default: t = 8'($urandom);
				endcase
				c = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ~d;
				if ($urandom_range(0, 9) == 0) begin
					// truncated frame: the next byte on the line closes it
					send_item(ACT_BYTE, SYNC_BYTE, 8'($urandom));
					send_item(ACT_BYTE, t, 8'($urandom));
					send_item(ACT_BYTE, d, 8'($urandom));
				end else begin
					send_frame(t, d, c);
				end
			end else if (r < 65) begin
				send_item(ACT_TICK, 8'($urandom), 8'($urandom));
			end else if (r < 75) begin
				send_item(ACT_INJECT, 8'($urandom), 8'($urandom));
			end else if (r < 85) begin
				send_item(ACT_POLL, 8'($urandom), 8'($urandom));
			end else begin
				send_item(ACT_BYTE, 8'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		snd_idle = 1'b1;
		rcv_idle = 1'b1;

		send_item(ACT_POLL, 8'h00, 8'hFF);
		send_item(ACT_BYTE, 8'h00, 8'h00);
		send_item(ACT_BYTE, 8'hFF, 8'hFF);
		send_frame(TYPE_BUTTONS, 8'hA5, 8'h5A);
		send_frame(TYPE_SYSTEM, 8'hFF, 8'h00);
		send_frame(TYPE_BUTTONS, 8'h00, 8'h00);
		send_frame(TYPE_PONG, 8'h12, 8'h34);
		send_frame(SYNC_BYTE, 8'h00, 8'hFF);
		send_item(ACT_INJECT, 8'h00, 8'hFF);
		send_item(ACT_POLL, 8'hFF, 8'h00);
		send_item(ACT_TICK, 8'h00, 8'h00);
		send_item(ACT_POLL, 8'hFF, 8'hFF);

		run_random(250);
		hold_req = 1'b1;
		run_random(60);
		wait_drain();
		run_random(100);

		configure(16'd1, 16'd1);
		run_random(200);
		configure(16'd0, 16'd0);
		run_random(150);
		configure(16'hFFFF, 16'hFFFF);
		run_random(100);

		// back-to-back tick burst with a live mask and link
		snd_idle = 1'b0;
		rcv_idle = 1'b0;
		send_frame(TYPE_PONG, 8'h00, 8'h00);
		send_item(ACT_INJECT, 8'h00, 8'hFF);
		for (int i = 0; i < 16; i++)
			send_item(ACT_TICK, 8'($urandom), 8'($urandom));
		send_item(ACT_POLL, 8'($urandom), 8'($urandom));
		snd_idle = 1'b1;
		rcv_idle = 1'b1;

		for (int i = 0; i < 5; i++) begin
			configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
			run_random(150);
		end

		configure(16'($urandom_range(2, 12)), 16'($urandom_range(2, 12)));
		snd_idle = 1'b0;
		rcv_idle = 1'b0;
		run_random(200);
		wait_drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
